// ===== sv/temh_pkg.sv =====
package temh_pkg;

	localparam int CAPACITY_DEF     = 1024;
	localparam int KEY_WIDTH_DEF    = 32;
	localparam int HANDLE_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF  = $clog2(CAPACITY_DEF + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_PEEK   = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

// ===== sv/temh_cmd_if.sv =====
interface temh_cmd_if #(
	parameter int KEY_WIDTH    = temh_pkg::KEY_WIDTH_DEF,
	parameter int HANDLE_WIDTH = temh_pkg::HANDLE_WIDTH_DEF
);
	logic                    valid;
	logic                    ready;
	logic [1:0]              opcode;
	logic [KEY_WIDTH-1:0]    due_time;
	logic [HANDLE_WIDTH-1:0] handle;

	modport source (output valid, output opcode, output due_time, output handle, input ready);
	modport sink (input valid, input opcode, input due_time, input handle, output ready);
endinterface

// ===== sv/temh_rpt_if.sv =====
interface temh_rpt_if #(
	parameter int KEY_WIDTH    = temh_pkg::KEY_WIDTH_DEF,
	parameter int HANDLE_WIDTH = temh_pkg::HANDLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = temh_pkg::COUNT_WIDTH_DEF
);
	logic                    valid;
	logic                    ready;
	logic                    top_valid;
	logic [KEY_WIDTH-1:0]    top_time;
	logic [HANDLE_WIDTH-1:0] top_handle;
	logic [COUNT_WIDTH-1:0]  entry_count;
	logic [1:0]              status;

	modport source (output valid, output top_valid, output top_time, output top_handle,
		output entry_count, output status, input ready);
	modport sink (input valid, input top_valid, input top_time, input top_handle,
		input entry_count, input status, output ready);
endinterface

// ===== sv/temh_ram.sv =====
module temh_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = temh_pkg::CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

// ===== sv/timed_event_min_heap.sv =====
// Binary min-heap of (due_time, handle) entries, smallest due_time on top.
// cmd channel (valid/ready): opcode 0 inserts {due_time, handle}, 1 removes the
// top entry, 2 (and 3) only peeks. rpt channel (valid/ready): one item per
// command with the top entry and entry_count after it, and a status:
// 0 ok, 1 insert refused because full, 2 remove on an empty heap.
// An empty heap reports top_valid 0 with zero time and handle.
// One command is in flight at a time; cmd.ready is high only while idle.
// Entries live in one dual-read RAM; each sift level is a read state and a
// compare/write-back state (S_UP_RD/S_UP_CMP up, S_DN_RD/S_DN_CMP down).
// cmd.ready returns at the edge that raises rpt.valid.
// The top entry is kept in a register, so peeks never touch the RAM.
// If rpt stalls, the previous item waits in the output register and the next
// command is not taken until the finished item can be loaded there.
// Reset (arst_n low) empties the heap at once; RAM contents are not cleared,
// entries beyond the count are never used.
module timed_event_min_heap #(
	parameter int CAPACITY     = temh_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH    = temh_pkg::KEY_WIDTH_DEF,
	parameter int HANDLE_WIDTH = temh_pkg::HANDLE_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	temh_cmd_if.sink  cmd,
	temh_rpt_if.source rpt
);
	import temh_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = AW + 2;
	localparam int DW = KEY_WIDTH + HANDLE_WIDTH;

	typedef struct packed {
		logic [KEY_WIDTH-1:0]    key;
		logic [HANDLE_WIDTH-1:0] hnd;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_RD,
		S_DN_CMP,
		S_FIN
	} state_t;

	state_t  state_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] pos_q;
	entry_t  mv_q;
	entry_t  root_q;
	status_t status_q;

	logic                    rpt_vld_q;
	logic                    top_vld_q;
	logic [KEY_WIDTH-1:0]    top_time_q;
	logic [HANDLE_WIDTH-1:0] top_hnd_q;
	logic [CW-1:0]           rpt_cnt_q;
	status_t                 rpt_st_q;

	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;
	logic [DW-1:0] rdata_a;
	logic [DW-1:0] rdata_b;
	entry_t        rd_a;
	entry_t        rd_b;

	logic [EW-1:0] kid_l;
	logic [EW-1:0] kid_r;
	logic [EW-1:0] cnt_x;
	logic          has_l;
	logic          has_r;
	logic          pick_r;
	entry_t        ch;
	logic [AW-1:0] ch_idx;
	logic [AW-1:0] par;
	logic          slot_free;

	temh_ram #(
		.WIDTH (DW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	assign rd_a = rdata_a;
	assign rd_b = rdata_b;

	assign kid_l  = {1'b0, pos_q, 1'b1};
	assign kid_r  = kid_l + EW'(1);
	assign cnt_x  = EW'(cnt_q);
	assign has_l  = kid_l < cnt_x;
	assign has_r  = kid_r < cnt_x;
	// right child only when strictly smaller
	assign pick_r = has_r && (rd_b.key < rd_a.key);
	assign ch     = pick_r ? rd_b : rd_a;
	assign ch_idx = pick_r ? kid_r[AW-1:0] : kid_l[AW-1:0];
	assign par    = (pos_q - AW'(1)) >> 1;

	assign slot_free = !rpt_vld_q || rpt.ready;
	assign cmd.ready = (state_q == S_IDLE);

	always_comb begin
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = mv_q;
		raddr_a = kid_l[AW-1:0];
		raddr_b = kid_r[AW-1:0];
		case (state_q)
			S_IDLE: begin
				// last entry, used when the command is a remove
				raddr_a = AW'(cnt_q - CW'(1));
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					raddr_a = par;
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (rd_a.key > mv_q.key) begin
					wdata = rd_a;
				end
			end
			S_DN_RD: begin
				if (!has_l) begin
					we = 1'b1;
				end
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (ch.key < mv_q.key) begin
					wdata = ch;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rpt_vld_q <= 1'b0;
		end else begin
			// a finishing item reloads the output register in the same cycle
			if (rpt_vld_q && rpt.ready && state_q != S_FIN) begin
				rpt_vld_q <= 1'b0;
			end
			if (we && waddr == '0) begin
				root_q <= wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						case (cmd.opcode)
							OP_INSERT: begin
								if (cnt_q >= CW'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_FIN;
								end else begin
									status_q <= ST_OK;
									mv_q.key <= cmd.due_time;
									mv_q.hnd <= cmd.handle;
									pos_q    <= AW'(cnt_q);
									cnt_q    <= cnt_q + CW'(1);
									state_q  <= S_UP_RD;
								end
							end
							OP_POP: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_FIN;
								end else begin
									status_q <= ST_OK;
									cnt_q <= cnt_q - CW'(1);
									if (cnt_q == CW'(1)) begin
										state_q <= S_FIN;
									end else begin
										state_q <= S_DN_LAST;
									end
								end
							end
							default: begin
								status_q <= ST_OK;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_UP_RD: begin
					if (pos_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (rd_a.key <= mv_q.key) begin
						state_q <= S_FIN;
					end else begin
						pos_q   <= par;
						state_q <= S_UP_RD;
					end
				end
				S_DN_LAST: begin
					mv_q    <= rd_a;
					pos_q   <= '0;
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					if (!has_l) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DN_CMP;
					end
				end
				S_DN_CMP: begin
					if (ch.key >= mv_q.key) begin
						state_q <= S_FIN;
					end else begin
						pos_q   <= ch_idx;
						state_q <= S_DN_RD;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						rpt_vld_q  <= 1'b1;
						top_vld_q  <= (cnt_q != '0);
						top_time_q <= (cnt_q != '0) ? root_q.key : '0;
						top_hnd_q  <= (cnt_q != '0) ? root_q.hnd : '0;
						rpt_cnt_q  <= cnt_q;
						rpt_st_q   <= status_q;
						state_q    <= S_IDLE;
					end else if (rpt_vld_q && rpt.ready) begin
						rpt_vld_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rpt.valid       = rpt_vld_q;
	assign rpt.top_valid   = top_vld_q;
	assign rpt.top_time    = top_time_q;
	assign rpt.top_handle  = top_hnd_q;
	assign rpt.entry_count = rpt_cnt_q;
	assign rpt.status      = rpt_st_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_top_matches_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_vld_q |-> (top_vld_q == (rpt_cnt_q != '0)))
		else $error("top_valid disagrees with entry_count");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q != S_IDLE && state_q != S_FIN))
		else $error("heap RAM written outside a sift");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.opcode == OP_INSERT && cnt_q < CW'(CAPACITY))
		|=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not grow the heap by one");
`endif
endmodule

// ===== test/heap_report_checker.sv =====
module heap_report_checker
	import temh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	temh_cmd_if         cmd,
	temh_rpt_if         rpt,
	output int unsigned outstanding,
	output int unsigned failures
);

	localparam int CAP = CAPACITY_DEF;
	localparam int KW  = KEY_WIDTH_DEF;
	localparam int HW  = HANDLE_WIDTH_DEF;
	localparam int CW  = COUNT_WIDTH_DEF;

	typedef struct packed {
		logic          top_valid;
		logic [KW-1:0] top_time;
		logic [HW-1:0] top_handle;
		logic [CW-1:0] entry_count;
		status_t       status;
	} report_t;

	// shadow heap, slot 0 holds the smallest key
	bit [KW-1:0] slot_key [CAP];
	bit [HW-1:0] slot_tag [CAP];
	int          held;

	report_t     expected_reports [$];
	int unsigned fail_tally;
	int unsigned reports_seen;

	initial begin
		fail_tally   = 0;
		reports_seen = 0;
		held         = 0;
	end

	function automatic report_t heap_apply(logic [1:0] op, logic [KW-1:0] key,
			logic [HW-1:0] tag);
		report_t     r;
		int          pos;
		int          up;
		int          kid;
		bit          moving;
		bit [KW-1:0] mkey;
		bit [HW-1:0] mtag;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_INSERT: begin
				if (held >= CAP) begin
					r.status = ST_FULL;
				end else begin
					pos = held;
					held++;
					moving = 1'b1;
					while (pos > 0 && moving) begin
						up = (pos - 1) / 2;
						if (slot_key[up] <= key) begin
							moving = 1'b0;
						end else begin
							slot_key[pos] = slot_key[up];
							slot_tag[pos] = slot_tag[up];
							pos = up;
						end
					end
					slot_key[pos] = key;
					slot_tag[pos] = tag;
				end
			end
			OP_POP: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					held--;
					if (held > 0) begin
						// last entry goes to the root and sinks; ties keep the left child
						mkey = slot_key[held];
						mtag = slot_tag[held];
						pos = 0;
						kid = 1;
						moving = 1'b1;
						while (kid < held && moving) begin
							if (kid + 1 < held && slot_key[kid + 1] < slot_key[kid])
								kid++;
							if (slot_key[kid] >= mkey) begin
								moving = 1'b0;
							end else begin
								slot_key[pos] = slot_key[kid];
								slot_tag[pos] = slot_tag[kid];
								pos = kid;
								kid = 2 * pos + 1;
							end
						end
						slot_key[pos] = mkey;
						slot_tag[pos] = mtag;
					end
				end
			end
			default: ; // peek, also the unused fourth code
		endcase
		if (held > 0) begin
			r.top_valid  = 1'b1;
			r.top_time   = slot_key[0];
			r.top_handle = slot_tag[0];
		end
		r.entry_count = CW'(held);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input longint unsigned seen,
			input longint unsigned wanted);
		fail_tally++;
		$display("%0t: report %0d, %s is %0h, predicted %0h", $time, reports_seen, field,
			seen, wanted);
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			held = 0;
			expected_reports.delete();
			outstanding <= 0;
			failures <= 0;
		end else begin
			if (cmd.valid && cmd.ready)
				expected_reports.push_back(heap_apply(cmd.opcode, cmd.due_time, cmd.handle));
			if (rpt.valid && rpt.ready) begin
				reports_seen++;
				if (expected_reports.size() == 0) begin
					report_mismatch("item with nothing pending, entry_count", rpt.entry_count, 0);
				end else begin
					want = expected_reports.pop_front();
					if (rpt.top_valid !== want.top_valid)
						report_mismatch("top_valid", rpt.top_valid, want.top_valid);
					if (rpt.top_time !== want.top_time)
						report_mismatch("top_time", rpt.top_time, want.top_time);
					if (rpt.top_handle !== want.top_handle)
						report_mismatch("top_handle", rpt.top_handle, want.top_handle);
					if (rpt.entry_count !== want.entry_count)
						report_mismatch("entry_count", rpt.entry_count, want.entry_count);
					if (rpt.status !== want.status)
						report_mismatch("status", rpt.status, want.status);
				end
			end
			outstanding <= expected_reports.size();
			failures <= fail_tally;
		end
	end

endmodule

// ===== test/testbench.sv =====
module testbench;
	import temh_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int LONG_HOLD = 300;
	localparam logic [1:0] OP_PEEK_ALT = 2'd3; // undefined code, behaves as peek

	logic        clk;
	logic        arst_n;
	int unsigned outstanding;
	int unsigned failures;

	bit calm;      // last part of the run: no idling on either side
	bit hold_req;  // asks the report side for one long hold-off
	int stock;     // entries the heap should hold, steers the stimulus
	int gap_pct;

	temh_cmd_if cmd_bus ();
	temh_rpt_if rpt_bus ();

	timed_event_min_heap i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rpt    (rpt_bus)
	);

	heap_report_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_bus),
		.rpt         (rpt_bus),
		.outstanding (outstanding),
		.failures    (failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2, 3, 4: return $urandom_range(0, 31); // lots of equal keys
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_tag();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [1:0] pick_op(int insert_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < insert_pct)
			return OP_INSERT;
		else if (r < 92)
			return OP_POP;
		else if (r < 96)
			return OP_PEEK;
		else
			return OP_PEEK_ALT;
	endfunction

	task automatic issue(input logic [1:0] op, input logic [31:0] key, input logic [15:0] tag);
		cmd_bus.valid <= 1'b1;
		cmd_bus.opcode <= op;
		cmd_bus.due_time <= key;
		cmd_bus.handle <= tag;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		if (op == OP_INSERT && stock < CAP)
			stock++;
		else if (op == OP_POP && stock > 0)
			stock--;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			cmd_bus.valid <= 1'b0;
			cmd_bus.opcode <= 2'($urandom);
			cmd_bus.due_time <= $urandom;
			cmd_bus.handle <= 16'($urandom);
			repeat ($urandom_range(1, 7))
				@(posedge clk);
		end
	endtask

	task automatic run_mix(input int n, input int insert_pct);
		repeat (n)
			issue(pick_op(insert_pct), pick_key(), pick_tag());
	endtask

	// report side: random stall bursts at a rate that changes now and then,
	// plus one long hold-off on request
	initial begin : rpt_side
		int  stall_pct;
		int  tick;
		bit  held_off;
		stall_pct = 10;
		tick = 0;
		held_off = 1'b0;
		rpt_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 50 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 5;
					2: stall_pct = 25;
					default: stall_pct = 50;
				endcase
			end
			if (hold_req && !held_off) begin
				held_off = 1'b1;
				rpt_bus.ready <= 1'b0;
				repeat (LONG_HOLD)
					@(posedge clk);
				rpt_bus.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				rpt_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 7))
					@(posedge clk);
				rpt_bus.ready <= 1'b1;
			end else begin
				rpt_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.opcode <= OP_PEEK;
		cmd_bus.due_time <= '0;
		cmd_bus.handle <= '0;
		calm <= 1'b0;
		hold_req <= 1'b0;
		stock = 0;
		gap_pct = 30;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty heap: peek, pop, undefined code
		issue(OP_PEEK, $urandom, 16'($urandom));
		issue(OP_POP, 32'h0, 16'h0);
		issue(OP_PEEK_ALT, 32'hFFFF_FFFF, 16'hFFFF);
		// extremes and ties
		issue(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		issue(OP_INSERT, 32'h0000_0000, 16'h0000);
		issue(OP_INSERT, 32'd7, 16'd1);
		issue(OP_INSERT, 32'd7, 16'd2);
		issue(OP_INSERT, 32'd7, 16'd3);
		issue(OP_INSERT, 32'h8000_0000, 16'h8000);
		issue(OP_INSERT, 32'd3, 16'h1234);
		issue(OP_PEEK, $urandom, 16'($urandom));
		issue(OP_PEEK_ALT, $urandom, 16'($urandom));
		repeat (8)
			issue(OP_POP, $urandom, 16'($urandom)); // last one hits the empty heap
		issue(OP_INSERT, 32'h0, 16'hFFFF);
		issue(OP_INSERT, 32'h0, 16'h0000);
		issue(OP_POP, 32'h0, 16'h0);
		issue(OP_POP, 32'h0, 16'h0);

		// mixed traffic; the first segment runs gap-free into a long report stall
		hold_req <= 1'b1;
		gap_pct = 0;
		run_mix(60, 75);
		for (int seg = 0; seg < 7; seg++) begin
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: run_mix(60, 35);
				1: run_mix(60, 55);
				default: run_mix(60, 75);
			endcase
		end

		// fill to capacity, then poke at the full heap
		gap_pct = 5;
		while (stock < CAP)
			issue(pick_op(90), pick_key(), pick_tag());
		repeat (4)
			issue(OP_INSERT, pick_key(), pick_tag());
		issue(OP_PEEK, $urandom, 16'($urandom));
		issue(OP_POP, $urandom, 16'($urandom));
		issue(OP_INSERT, 32'h0, 16'($urandom)); // smallest key, climbs until it meets an equal key or the root
		issue(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);

		// drain, mostly pops with deep sift-downs
		while (stock > 0)
			issue(pick_op(8), pick_key(), pick_tag());
		issue(OP_POP, $urandom, 16'($urandom));
		issue(OP_POP, $urandom, 16'($urandom));

		calm <= 1'b1;
		run_mix(150, 50);

		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
